// ===== design/pad_pkg.sv =====
// Shared types and constants for the pixel adjust and difference block.
// Used by the register file, both pipeline sections and the top level.
// No dependencies.
package pad_pkg;

  // Pixel channel full scale
  localparam logic [7:0] PIX_MAX = 8'd255;

  // Brightness limits (two's complement, 8 bits)
  localparam logic signed [7:0] BRI_HI = 8'sd100;
  localparam logic signed [7:0] BRI_LO = -8'sd100;

  // floor(n/3) == (n*683) >> 11 for every n below 2048
  localparam logic [9:0] DIV3_RECIP = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  // Contrast is unsigned Q4.8
  localparam int unsigned CON_FRAC = 8;

  // APB address width: eight 32-bit registers
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register indexes
  typedef enum logic [2:0] {
    REG_DIFF_MODE  = 3'd0,
    REG_GRAY_EN    = 3'd1,
    REG_CHAN_MASK  = 3'd2,
    REG_INVERT_EN  = 3'd3,
    REG_ADJUST_EN  = 3'd4,
    REG_BRIGHTNESS = 3'd5,
    REG_CONTRAST   = 3'd6,
    REG_DIFF_GAIN  = 3'd7
  } reg_idx_t;

  // Channel mask bits
  localparam int unsigned MASK_RED   = 0;
  localparam int unsigned MASK_GREEN = 1;
  localparam int unsigned MASK_BLUE  = 2;
  localparam int unsigned MASK_ALPHA = 3;

  // Reset values
  localparam logic [3:0]  RST_CHAN_MASK = 4'd7;
  localparam logic [11:0] RST_CONTRAST  = 12'd256;
  localparam logic [7:0]  RST_DIFF_GAIN = 8'd1;

  // Configuration seen by the datapath
  typedef struct packed {
    logic              diff_mode;
    logic              gray_enable;
    logic [3:0]        channel_mask;
    logic              invert_enable;
    logic              adjust_enable;
    logic signed [7:0] bri_clamped;
    logic [11:0]       contrast;
    logic [7:0]        diff_gain;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

endpackage

// ===== design/pad_if.sv =====
// Stream interfaces for the pixel adjust and difference block.
// Input channel carries processed and reference pixel, output channel the result.
// No dependencies.
interface pad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] proc_red;
  logic [7:0] proc_green;
  logic [7:0] proc_blue;
  logic [7:0] proc_alpha;
  logic [7:0] ref_red;
  logic [7:0] ref_green;
  logic [7:0] ref_blue;

  modport source (
    output valid, proc_red, proc_green, proc_blue, proc_alpha,
           ref_red, ref_green, ref_blue,
    input  ready
  );
  modport sink (
    input  valid, proc_red, proc_green, proc_blue, proc_alpha,
           ref_red, ref_green, ref_blue,
    output ready
  );
endinterface

interface pad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

// ===== design/pad_regs.sv =====
// APB configuration registers of the pixel adjust and difference block.
// Depends on pad_pkg.
module pad_regs
  import pad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic              diff_mode;
  logic              gray_enable;
  logic [3:0]        channel_mask;
  logic              invert_enable;
  logic              adjust_enable;
  logic signed [7:0] brightness;
  logic [11:0]       contrast;
  logic [7:0]        diff_gain;
  logic              wr_en;
  reg_idx_t          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_mode     <= 1'b0;
      gray_enable   <= 1'b0;
      channel_mask  <= RST_CHAN_MASK;
      invert_enable <= 1'b0;
      adjust_enable <= 1'b0;
      brightness    <= 8'sd0;
      contrast      <= RST_CONTRAST;
      diff_gain     <= RST_DIFF_GAIN;
    end else if (wr_en) begin
      case (idx)
        REG_DIFF_MODE:  diff_mode     <= pwdata[0];
        REG_GRAY_EN:    gray_enable   <= pwdata[0];
        REG_CHAN_MASK:  channel_mask  <= pwdata[3:0];
        REG_INVERT_EN:  invert_enable <= pwdata[0];
        REG_ADJUST_EN:  adjust_enable <= pwdata[0];
        REG_BRIGHTNESS: brightness    <= $signed(pwdata[7:0]);
        REG_CONTRAST:   contrast      <= pwdata[11:0];
        REG_DIFF_GAIN:  diff_gain     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_DIFF_MODE:  prdata = DATA_W'(diff_mode);
      REG_GRAY_EN:    prdata = DATA_W'(gray_enable);
      REG_CHAN_MASK:  prdata = DATA_W'(channel_mask);
      REG_INVERT_EN:  prdata = DATA_W'(invert_enable);
      REG_ADJUST_EN:  prdata = DATA_W'(adjust_enable);
      REG_BRIGHTNESS: prdata = DATA_W'($unsigned(brightness));
      REG_CONTRAST:   prdata = DATA_W'(contrast);
      REG_DIFF_GAIN:  prdata = DATA_W'(diff_gain);
      default:        prdata = '0;
    endcase
  end

  // Datapath view, brightness limited to +/-100
  always_comb begin
    cfg.diff_mode     = diff_mode;
    cfg.gray_enable   = gray_enable;
    cfg.channel_mask  = channel_mask;
    cfg.invert_enable = invert_enable;
    cfg.adjust_enable = adjust_enable;
    cfg.contrast      = contrast;
    cfg.diff_gain     = diff_gain;
    if (brightness > BRI_HI) begin
      cfg.bri_clamped = BRI_HI;
    end else if (brightness < BRI_LO) begin
      cfg.bri_clamped = BRI_LO;
    end else begin
      cfg.bri_clamped = brightness;
    end
  end

  // Limited brightness never leaves its range
  a_bri_range: assert property (@(posedge clk) disable iff (rst)
    (cfg.bri_clamped <= BRI_HI) && (cfg.bri_clamped >= BRI_LO))
    else $error("brightness limit out of range");

endmodule

// ===== design/pad_front.sv =====
// Front pipeline: difference, grey and mask selection, gain and divide-by-3 multiply,
// saturation and inversion. Three register stages. Depends on pad_pkg and pad_if.
module pad_front
  import pad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  pad_in_if.sink    pix_in,
  output logic      dn_valid,
  input  logic      dn_ready,
  output pix_t      dn_pix
);

  // Stage 1: absolute differences, channel sum, masked pixel
  logic       v1;
  logic [7:0] d1_r, d1_g, d1_b;
  logic [9:0] sum1;
  pix_t       m1;
  // Stage 2: gain products, scaled sum
  logic       v2;
  logic [15:0] p2_r, p2_g, p2_b;
  logic [19:0] q2;
  pix_t        m2;
  // Stage 3: selected and inverted pixel
  logic       v3;
  pix_t       s3;
  pix_t       s3_next;

  logic en1, en2, en3;
  logic [7:0] dr, dg, db;
  logic [7:0] grey;

  // Bubble-collapsing advance: a stage loads when empty or when it drains
  assign en3 = !v3 || dn_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign pix_in.ready = en1;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] sat8(input logic [15:0] p);
    sat8 = (p > 16'(PIX_MAX)) ? PIX_MAX : p[7:0];
  endfunction

  assign dr = absdiff(pix_in.ref_red, pix_in.proc_red);
  assign dg = absdiff(pix_in.ref_green, pix_in.proc_green);
  assign db = absdiff(pix_in.ref_blue, pix_in.proc_blue);

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= pix_in.valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // Stage 1 data
  always_ff @(posedge clk) begin
    if (en1) begin
      d1_r     <= dr;
      d1_g     <= dg;
      d1_b     <= db;
      sum1     <= 10'(pix_in.proc_red) + 10'(pix_in.proc_green) + 10'(pix_in.proc_blue);
      m1.red   <= cfg.channel_mask[MASK_RED]   ? pix_in.proc_red   : 8'd0;
      m1.green <= cfg.channel_mask[MASK_GREEN] ? pix_in.proc_green : 8'd0;
      m1.blue  <= cfg.channel_mask[MASK_BLUE]  ? pix_in.proc_blue  : 8'd0;
      m1.alpha <= cfg.channel_mask[MASK_ALPHA] ? PIX_MAX : pix_in.proc_alpha;
    end
  end

  // Stage 2 data: one multiplier per channel
  always_ff @(posedge clk) begin
    if (en2) begin
      p2_r <= 16'(d1_r) * 16'(cfg.diff_gain);
      p2_g <= 16'(d1_g) * 16'(cfg.diff_gain);
      p2_b <= 16'(d1_b) * 16'(cfg.diff_gain);
      q2   <= 20'(sum1) * 20'(DIV3_RECIP);
      m2   <= m1;
    end
  end

  // Stage 3: mode select, saturation, inversion
  assign grey = q2[DIV3_SHIFT +: 8];

  always_comb begin
    if (cfg.diff_mode) begin
      s3_next.red   = sat8(p2_r);
      s3_next.green = sat8(p2_g);
      s3_next.blue  = sat8(p2_b);
      s3_next.alpha = PIX_MAX;
    end else begin
      if (cfg.gray_enable) begin
        s3_next.red   = grey;
        s3_next.green = grey;
        s3_next.blue  = grey;
        s3_next.alpha = PIX_MAX;
      end else begin
        s3_next = m2;
      end
      if (cfg.invert_enable) begin
        s3_next.red   = ~s3_next.red;
        s3_next.green = ~s3_next.green;
        s3_next.blue  = ~s3_next.blue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en3) s3 <= s3_next;
  end

  assign dn_valid = v3;
  assign dn_pix   = s3;

  // A held item stays put while downstream stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v3 && !dn_ready) |=> (v3 && $stable(s3)))
    else $error("front stage 3 lost or changed a stalled pixel");

  // The scaled channel sum stays below 766 times the reciprocal, so the channel sum is at most 765
  a_grey_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (q2 < 20'(10'd766) * 20'(DIV3_RECIP)))
    else $error("channel sum out of range");

endmodule

// ===== design/pad_adjust.sv =====
// Back pipeline: contrast multiply, brightness add and clamp, output register.
// Two register stages. Depends on pad_pkg and pad_if.
module pad_adjust
  import pad_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  pix_t      up_pix,
  pad_out_if.source pix_out
);

  // Stage 4: scaled channels and bypass copy
  logic        v4;
  logic [11:0] k4_r, k4_g, k4_b;
  pix_t        p4;
  // Stage 5: output register
  logic        v5;
  pix_t        s5;
  pix_t        s5_next;
  logic [19:0] prod_r, prod_g, prod_b;
  logic        en4, en5;

  assign en5 = !v5 || pix_out.ready;
  assign en4 = !v4 || en5;
  assign up_ready = en4;

  function automatic logic [7:0] add_clamp(input logic [11:0] k, input logic signed [7:0] bri);
    logic signed [13:0] s;
    s = $signed({2'b00, k}) + 14'(bri);
    if (s < 14'sd0) begin
      add_clamp = 8'd0;
    end else if (s > $signed(14'(PIX_MAX))) begin
      add_clamp = PIX_MAX;
    end else begin
      add_clamp = s[7:0];
    end
  endfunction

  assign prod_r = 20'(up_pix.red)   * 20'(cfg.contrast);
  assign prod_g = 20'(up_pix.green) * 20'(cfg.contrast);
  assign prod_b = 20'(up_pix.blue)  * 20'(cfg.contrast);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (en4) v4 <= up_valid;
      if (en5) v5 <= v4;
    end
  end

  // Stage 4: Q4.8 product, fraction dropped
  always_ff @(posedge clk) begin
    if (en4) begin
      k4_r <= prod_r[CON_FRAC +: 12];
      k4_g <= prod_g[CON_FRAC +: 12];
      k4_b <= prod_b[CON_FRAC +: 12];
      p4   <= up_pix;
    end
  end

  // Stage 5: brightness offset and clamp, or bypass
  always_comb begin
    s5_next = p4;
    if (cfg.adjust_enable) begin
      s5_next.red   = add_clamp(k4_r, cfg.bri_clamped);
      s5_next.green = add_clamp(k4_g, cfg.bri_clamped);
      s5_next.blue  = add_clamp(k4_b, cfg.bri_clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (en5) s5 <= s5_next;
  end

  assign pix_out.valid     = v5;
  assign pix_out.out_red   = s5.red;
  assign pix_out.out_green = s5.green;
  assign pix_out.out_blue  = s5.blue;
  assign pix_out.out_alpha = s5.alpha;

  // Alpha passes through the adjust section untouched
  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    (v4 && en5) |=> (s5.alpha == $past(p4.alpha)))
    else $error("alpha changed in adjust section");

  // With adjust off the pixel bypasses unchanged
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (v4 && en5 && !cfg.adjust_enable) |=> (s5 == $past(p4)))
    else $error("bypass pixel altered");

endmodule

// ===== design/pixel_adjust_and_diff_top.sv =====
// Structure: five register stages, three in pad_front and two in pad_adjust.
// Throughput: one pixel per clock unless pix_out stalls; multipliers feed stages 2 and 4.
// Stalls collapse bubbles stage by stage, so input is taken while a result waits until
// the stages fill. Reset (synchronous, rst high) clears all pipeline valid bits and loads
// the defaults: diff 0, grey 0, mask 7, invert 0, adjust 0, brightness 0, contrast 256, gain 1.
// Top level: instantiates pad_regs, pad_front and pad_adjust; depends on pad_pkg, pad_if.
module pixel_adjust_and_diff_top
  import pad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  pad_in_if.sink            pix_in,
  pad_out_if.source         pix_out
);

  cfg_t cfg;
  logic mid_valid;
  logic mid_ready;
  pix_t mid_pix;

  pad_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pad_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pix_in   (pix_in),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_pix   (mid_pix)
  );

  pad_adjust u_adjust (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_pix   (mid_pix),
    .pix_out  (pix_out)
  );

endmodule
